>>> hw/rtl/tlrg_pkg.sv
// shared constants and types for the thin-lens ray generator
`timescale 1ns / 1ps
package tlrg_pkg;

  localparam int NUM_REGS     = 6;
  localparam int CFG_IDX_BITS = 3;
  localparam int NORM_BITS    = 30;
  localparam int SUM_BITS     = 2 * NORM_BITS + 2;
  localparam int ROOT_BITS    = NORM_BITS + 1;
  localparam int HEAD_BITS    = 16;
  localparam int HEAD_FRAC    = 15;
  localparam int QUOT_BITS    = HEAD_BITS;

  localparam logic [HEAD_BITS-1:0] HEAD_MAX = 16'h7fff;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LENS_CENTER  = 3'd0,
    REG_LENS_U       = 3'd1,
    REG_LENS_V       = 3'd2,
    REG_PLANE_CORNER = 3'd3,
    REG_PLANE_X_SPAN = 3'd4,
    REG_PLANE_Y_SPAN = 3'd5
  } cfg_reg_e;

endpackage

>>> hw/rtl/thin_lens_ray_generator.sv
// thin-lens camera ray generator top level
//
//  channel    dir   handshake                      contents
//  s_axis     in    s_axis_tvalid / s_axis_tready  screen x/y, lens sample x/y
//  m_axis     out   m_axis_tvalid / m_axis_tready  ray origin, unit heading, degenerate flag
//  cfg        in    cfg_we_i                       six packed camera vectors
//
// one ray per clock while the output is not stalled; the longest parts of the pipeline are
// the 31-stage square root and the 17-stage divider that follows it
// all stages advance together on one enable, taken when the output register is
// empty or its beat is taken; a stall holds every stage in place
// reset clears the valid bits and the camera registers; no clearing pass is needed
`timescale 1ns / 1ps
module thin_lens_ray_generator #(
  parameter int COMPONENT_BITS = 21,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // screen_x, screen_y, lens_sample_x, lens_sample_y
  input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]         s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // origin_x, origin_y, origin_z, heading_x, heading_y, heading_z
  output logic [((3*COMPONENT_BITS+48+7)/8)*8-1:0]   m_axis_tdata,
  // degenerate
  output logic                                       m_axis_tuser,
  input  logic                                       cfg_we_i,
  input  logic [tlrg_pkg::CFG_IDX_BITS-1:0]          cfg_idx_i,
  input  logic [3*COMPONENT_BITS-1:0]                cfg_data_i
);
  import tlrg_pkg::*;

  localparam int C     = COMPONENT_BITS;
  localparam int S     = SAMPLE_BITS;
  localparam int MW    = C + S + 2;
  localparam int OUT_W = ((3 * C + 3 * HEAD_BITS + 7) / 8) * 8;
  localparam int SBA_W = 3 * C + 3;
  localparam int SBQ_W = SBA_W + 1 + 3 * NORM_BITS;
  localparam int SBD_W = SBA_W + 1;

  logic en;
  logic out_vld_q;
  logic [OUT_W-1:0] out_data_q;
  logic out_degen_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // front end
  logic                  fr_vld;
  logic [2:0][C-1:0]     fr_origin;
  logic [2:0]            fr_neg;
  logic [2:0][MW-1:0]    fr_mag;
  logic [MW-1:0]         fr_ormag;

  tlrg_front #(
    .COMPONENT_BITS(C),
    .SAMPLE_BITS   (S)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .vld_i          (s_axis_tvalid),
    .screen_x_i     (s_axis_tdata[S-1:0]),
    .screen_y_i     (s_axis_tdata[2*S-1:S]),
    .lens_sample_x_i(s_axis_tdata[3*S-1:2*S]),
    .lens_sample_y_i(s_axis_tdata[4*S-1:3*S]),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .vld_o          (fr_vld),
    .origin_o       (fr_origin),
    .neg_o          (fr_neg),
    .mag_o          (fr_mag),
    .ormag_o        (fr_ormag)
  );

  // scaling and sum of squares
  logic                       nr_vld;
  logic [2:0][NORM_BITS-1:0]  nr_nmag;
  logic [SUM_BITS-1:0]        nr_sum;
  logic                       nr_degen;
  logic [SBA_W-1:0]           nr_sb;
  logic [NORM_BITS-1:0]       nr_or;

  tlrg_norm #(
    .MAG_BITS(MW),
    .SB_W    (SBA_W)
  ) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fr_vld),
    .mag_i  (fr_mag),
    .ormag_i(fr_ormag),
    .sb_i   ({fr_neg, fr_origin}),
    .vld_o  (nr_vld),
    .nmag_o (nr_nmag),
    .sum_o  (nr_sum),
    .degen_o(nr_degen),
    .sb_o   (nr_sb)
  );

  assign nr_or = nr_nmag[0] | nr_nmag[1] | nr_nmag[2];

  // length
  logic                   sq_vld;
  logic [ROOT_BITS-1:0]   sq_root;
  logic [SBQ_W-1:0]       sq_sb;

  tlrg_sqrt #(
    .SB_W(SBQ_W)
  ) u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (nr_vld),
    .n_i   (nr_sum),
    .sb_i  ({nr_sb, nr_degen, nr_nmag}),
    .vld_o (sq_vld),
    .root_o(sq_root),
    .sb_o  (sq_sb)
  );

  // heading quotients
  logic                       dv_vld;
  logic [2:0][QUOT_BITS-1:0]  dv_quo;
  logic [SBD_W-1:0]           dv_sb;
  logic [2:0][C-1:0]          dv_origin;
  logic [2:0]                 dv_neg;
  logic                       dv_degen;

  tlrg_div #(
    .SB_W(SBD_W)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (sq_vld),
    .len_i (sq_root),
    .mag_i (sq_sb[3*NORM_BITS-1:0]),
    .sb_i  (sq_sb[SBQ_W-1:3*NORM_BITS]),
    .vld_o (dv_vld),
    .quo_o (dv_quo),
    .sb_o  (dv_sb)
  );

  assign dv_degen  = dv_sb[0];
  assign dv_origin = dv_sb[3*C:1];
  assign dv_neg    = dv_sb[SBD_W-1:3*C+1];

  // sign, clamp at plus one, and zero for a degenerate ray
  logic [2:0][HEAD_BITS-1:0] head_d;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_degen) begin
        head_d[k] = '0;
      end else if (dv_neg[k]) begin
        head_d[k] = HEAD_BITS'(-dv_quo[k]);
      end else if (dv_quo[k][QUOT_BITS-1]) begin
        head_d[k] = HEAD_MAX;
      end else begin
        head_d[k] = dv_quo[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q  <= OUT_W'({head_d, dv_origin});
      out_degen_q <= dv_degen;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_degen_q;

  // a nonzero direction is scaled so its largest component has the top bit set
  a_norm_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nr_vld && !nr_degen) |-> nr_or[NORM_BITS-1])
    else $error("scaled direction lacks leading one");

  // each component is at most the length, so no quotient exceeds one
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld && !dv_degen) |-> ((dv_quo[0] <= 16'h8000) && (dv_quo[1] <= 16'h8000) &&
                               (dv_quo[2] <= 16'h8000)))
    else $error("heading quotient above one");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[3*C+3*HEAD_BITS-1:3*C] == '0))
    else $error("degenerate beat carries a heading");

endmodule

>>> hw/rtl/tlrg_front.sv
// camera registers, lens and plane point products, origin rounding and difference magnitude
`timescale 1ns / 1ps
module tlrg_front #(
  parameter int COMPONENT_BITS = 21,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    vld_i,
  input  logic [SAMPLE_BITS-1:0]                  screen_x_i,
  input  logic [SAMPLE_BITS-1:0]                  screen_y_i,
  input  logic [SAMPLE_BITS-1:0]                  lens_sample_x_i,
  input  logic [SAMPLE_BITS-1:0]                  lens_sample_y_i,
  input  logic                                    cfg_we_i,
  input  logic [tlrg_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [3*COMPONENT_BITS-1:0]             cfg_data_i,
  output logic                                    vld_o,
  output logic [2:0][COMPONENT_BITS-1:0]          origin_o,
  output logic [2:0]                              neg_o,
  output logic [2:0][COMPONENT_BITS+SAMPLE_BITS+1:0] mag_o,
  output logic [COMPONENT_BITS+SAMPLE_BITS+1:0]   ormag_o
);
  import tlrg_pkg::*;

  localparam int C  = COMPONENT_BITS;
  localparam int S  = SAMPLE_BITS;
  localparam int LW = C + S + 2;
  localparam int XW = C + S + 1;
  localparam int DW = C + S + 3;
  localparam int MW = C + S + 2;

  localparam logic signed [DW-1:0] ORG_MAX = DW'(2 ** (C - 1) - 1);
  localparam logic signed [DW-1:0] ORG_MIN = ~ORG_MAX;
  localparam logic signed [DW-1:0] HALF    = DW'(2 ** (S - 1));

  logic [NUM_REGS-1:0][2:0][C-1:0] cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i <= REG_PLANE_Y_SPAN)) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // stage 1: lens offsets and products
  logic signed [S+1:0] du, dv;
  logic signed [S:0]   sxe, sye;
  assign du  = $signed({1'b0, lens_sample_x_i, 1'b0}) - $signed({2'b01, {S{1'b0}}});
  assign dv  = $signed({1'b0, lens_sample_y_i, 1'b0}) - $signed({2'b01, {S{1'b0}}});
  assign sxe = $signed({1'b0, screen_x_i});
  assign sye = $signed({1'b0, screen_y_i});

  logic                 vld1_q, vld2_q, vld3_q;
  logic signed [LW-1:0] pu_q [3];
  logic signed [LW-1:0] pv_q [3];
  logic signed [XW-1:0] px_q [3];
  logic signed [XW-1:0] py_q [3];
  logic signed [LW-1:0] lens_q [3];
  logic signed [DW-1:0] diff_q [3];
  logic signed [LW-1:0] lens_d [3];
  logic signed [DW-1:0] diff_d [3];
  logic [2:0][C-1:0]    origin_d;
  logic [2:0]           neg_d;
  logic [2:0][MW-1:0]   mag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        pu_q[k]   <= du * $signed(cfg_q[REG_LENS_U][k]);
        pv_q[k]   <= dv * $signed(cfg_q[REG_LENS_V][k]);
        px_q[k]   <= sxe * $signed(cfg_q[REG_PLANE_X_SPAN][k]);
        py_q[k]   <= sye * $signed(cfg_q[REG_PLANE_Y_SPAN][k]);
        lens_q[k] <= lens_d[k];
        diff_q[k] <= diff_d[k];
      end
      origin_o <= origin_d;
      neg_o    <= neg_d;
      mag_o    <= mag_d;
      ormag_o  <= mag_d[0] | mag_d[1] | mag_d[2];
    end
  end

  // stage 2: lens point and image point, full precision
  always_comb begin
    logic signed [LW-1:0] cterm, pterm, img;
    for (int k = 0; k < 3; k++) begin
      cterm = $signed({{2{cfg_q[REG_LENS_CENTER][k][C-1]}}, cfg_q[REG_LENS_CENTER][k],
                       {S{1'b0}}});
      pterm = $signed({{2{cfg_q[REG_PLANE_CORNER][k][C-1]}}, cfg_q[REG_PLANE_CORNER][k],
                       {S{1'b0}}});
      lens_d[k] = cterm + pu_q[k] + pv_q[k];
      img       = pterm + LW'(px_q[k]) + LW'(py_q[k]);
      diff_d[k] = DW'(img) - DW'(lens_d[k]);
    end
  end

  // stage 3: round half up, saturate, split sign and magnitude
  always_comb begin
    logic signed [DW-1:0] rnd;
    logic [DW-1:0]        ad;
    for (int k = 0; k < 3; k++) begin
      rnd = (DW'(lens_q[k]) + HALF) >>> S;
      if (rnd > ORG_MAX) begin
        origin_d[k] = ORG_MAX[C-1:0];
      end else if (rnd < ORG_MIN) begin
        origin_d[k] = ORG_MIN[C-1:0];
      end else begin
        origin_d[k] = rnd[C-1:0];
      end
      neg_d[k] = diff_q[k][DW-1];
      ad       = neg_d[k] ? DW'(-diff_q[k]) : DW'(diff_q[k]);
      mag_d[k] = ad[MW-1:0];
    end
  end

  assign vld_o = vld3_q;

endmodule

>>> hw/rtl/tlrg_norm.sv
// common power-of-two scaling of the direction and sum of squares
`timescale 1ns / 1ps
module tlrg_norm #(
  parameter int MAG_BITS = 39,
  parameter int SB_W     = 66
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic                                     vld_i,
  input  logic [2:0][MAG_BITS-1:0]                 mag_i,
  input  logic [MAG_BITS-1:0]                      ormag_i,
  input  logic [SB_W-1:0]                          sb_i,
  output logic                                     vld_o,
  output logic [2:0][tlrg_pkg::NORM_BITS-1:0]      nmag_o,
  output logic [tlrg_pkg::SUM_BITS-1:0]            sum_o,
  output logic                                     degen_o,
  output logic [SB_W-1:0]                          sb_o
);
  import tlrg_pkg::*;

  localparam int LZW = $clog2(MAG_BITS + 1);
  localparam int EW  = MAG_BITS + NORM_BITS;

  logic                        a_vld_q, b_vld_q, c_vld_q, d_vld_q;
  logic [2:0][MAG_BITS-1:0]    a_mag_q;
  logic [LZW-1:0]              a_lz_q;
  logic                        a_degen_q, b_degen_q, c_degen_q, d_degen_q;
  logic [SB_W-1:0]             a_sb_q, b_sb_q, c_sb_q, d_sb_q;
  logic [2:0][NORM_BITS-1:0]   b_nmag_q, c_nmag_q, d_nmag_q;
  logic [2:0][2*NORM_BITS-1:0] c_sq_q;
  logic [SUM_BITS-1:0]         d_sum_q;
  logic [LZW-1:0]              lz_d;
  logic [2:0][NORM_BITS-1:0]   nmag_d;

  // leading zero count of the largest magnitude
  always_comb begin
    lz_d = '0;
    for (int i = 0; i < MAG_BITS; i++) begin
      if (ormag_i[i]) lz_d = LZW'(MAG_BITS - 1 - i);
    end
  end

  // the leading one lands on the top bit of the scaled field
  always_comb begin
    logic [EW-1:0] sh;
    for (int k = 0; k < 3; k++) begin
      sh        = {a_mag_q[k], {NORM_BITS{1'b0}}} << a_lz_q;
      nmag_d[k] = sh[EW-1 -: NORM_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mag_q   <= mag_i;
      a_lz_q    <= lz_d;
      a_degen_q <= (ormag_i == '0);
      a_sb_q    <= sb_i;
      b_nmag_q  <= nmag_d;
      b_degen_q <= a_degen_q;
      b_sb_q    <= a_sb_q;
      for (int k = 0; k < 3; k++) begin
        c_sq_q[k] <= b_nmag_q[k] * b_nmag_q[k];
      end
      c_nmag_q  <= b_nmag_q;
      c_degen_q <= b_degen_q;
      c_sb_q    <= b_sb_q;
      d_sum_q   <= SUM_BITS'(c_sq_q[0]) + SUM_BITS'(c_sq_q[1]) + SUM_BITS'(c_sq_q[2]);
      d_nmag_q  <= c_nmag_q;
      d_degen_q <= c_degen_q;
      d_sb_q    <= c_sb_q;
    end
  end

  assign vld_o   = d_vld_q;
  assign nmag_o  = d_nmag_q;
  assign sum_o   = d_sum_q;
  assign degen_o = d_degen_q;
  assign sb_o    = d_sb_q;

endmodule

>>> hw/rtl/tlrg_sqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module tlrg_sqrt #(
  parameter int SB_W = 157
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic [tlrg_pkg::SUM_BITS-1:0]     n_i,
  input  logic [SB_W-1:0]                   sb_i,
  output logic                              vld_o,
  output logic [tlrg_pkg::ROOT_BITS-1:0]    root_o,
  output logic [SB_W-1:0]                   sb_o
);
  import tlrg_pkg::*;

  localparam int REM_BITS = ROOT_BITS + 2;

  logic                 vld  [ROOT_BITS+1];
  logic [REM_BITS-1:0]  rem  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] root [ROOT_BITS+1];
  logic [SUM_BITS-1:0]  n    [ROOT_BITS+1];
  logic [SB_W-1:0]      sb   [ROOT_BITS+1];

  assign vld[0]  = vld_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign n[0]    = n_i;
  assign sb[0]   = sb_i;

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_step
    logic [REM_BITS+1:0] rem_t;
    logic [REM_BITS+1:0] trial;

    assign rem_t = {rem[j], n[j][SUM_BITS-1 -: 2]};
    assign trial = (REM_BITS + 2)'({root[j], 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[j+1] <= 1'b0;
      end else if (en_i) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_t >= trial) begin
          rem[j+1]  <= REM_BITS'(rem_t - trial);
          root[j+1] <= {root[j][ROOT_BITS-2:0], 1'b1};
        end else begin
          rem[j+1]  <= REM_BITS'(rem_t);
          root[j+1] <= {root[j][ROOT_BITS-2:0], 1'b0};
        end
        n[j+1]  <= {n[j][SUM_BITS-3:0], 2'b00};
        sb[j+1] <= sb[j];
      end
    end
  end

  assign vld_o  = vld[ROOT_BITS];
  assign root_o = root[ROOT_BITS];
  assign sb_o   = sb[ROOT_BITS];

endmodule

>>> hw/rtl/tlrg_div.sv
// three-lane pipelined restoring divider for the rounded heading quotients
`timescale 1ns / 1ps
module tlrg_div #(
  parameter int SB_W = 67
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  vld_i,
  input  logic [tlrg_pkg::ROOT_BITS-1:0]        len_i,
  input  logic [2:0][tlrg_pkg::NORM_BITS-1:0]   mag_i,
  input  logic [SB_W-1:0]                       sb_i,
  output logic                                  vld_o,
  output logic [2:0][tlrg_pkg::QUOT_BITS-1:0]   quo_o,
  output logic [SB_W-1:0]                       sb_o
);
  import tlrg_pkg::*;

  localparam int DVW = NORM_BITS + HEAD_FRAC + 1;

  logic                            vld  [QUOT_BITS+1];
  logic [2:0][ROOT_BITS-1:0]       rem  [QUOT_BITS+1];
  logic [2:0][QUOT_BITS-1:0]       low  [QUOT_BITS+1];
  logic [2:0][QUOT_BITS-1:0]       quo  [QUOT_BITS+1];
  logic [ROOT_BITS-1:0]            len  [QUOT_BITS+1];
  logic [SB_W-1:0]                 sb   [QUOT_BITS+1];

  // dividend m*2^15 + len/2; its quotient fits the low bits, so the top starts below len
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else if (en_i) begin
      vld[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [DVW-1:0] dvd;
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        dvd       = {1'b0, mag_i[k], {HEAD_FRAC{1'b0}}} + DVW'(len_i >> 1);
        rem[0][k] <= ROOT_BITS'(dvd[DVW-1:QUOT_BITS]);
        low[0][k] <= dvd[QUOT_BITS-1:0];
      end
      quo[0] <= '0;
      len[0] <= len_i;
      sb[0]  <= sb_i;
    end
  end

  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[j+1] <= 1'b0;
      end else if (en_i) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk_i) begin
      logic [ROOT_BITS:0] rem_t;
      if (en_i) begin
        for (int k = 0; k < 3; k++) begin
          rem_t = {rem[j][k], low[j][k][QUOT_BITS-1]};
          if (rem_t >= {1'b0, len[j]}) begin
            rem[j+1][k] <= ROOT_BITS'(rem_t - {1'b0, len[j]});
            quo[j+1][k] <= {quo[j][k][QUOT_BITS-2:0], 1'b1};
          end else begin
            rem[j+1][k] <= ROOT_BITS'(rem_t);
            quo[j+1][k] <= {quo[j][k][QUOT_BITS-2:0], 1'b0};
          end
          low[j+1][k] <= {low[j][k][QUOT_BITS-2:0], 1'b0};
        end
        len[j+1] <= len[j];
        sb[j+1]  <= sb[j];
      end
    end
  end

  assign vld_o = vld[QUOT_BITS];
  assign quo_o = quo[QUOT_BITS];
  assign sb_o  = sb[QUOT_BITS];

endmodule

>>> bench/thin_lens_ray_generator_test.sv
// self-checking testbench for the thin-lens ray generator
`timescale 1ns / 1ps
module thin_lens_ray_generator_test;
  import tlrg_pkg::*;

  localparam int CB = 21;
  localparam int SB = 16;
  localparam int LATENCY = 56;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_RAYS = 1500;

  typedef struct packed {
    logic [15:0] lens_y;
    logic [15:0] lens_x;
    logic [15:0] scr_y;
    logic [15:0] scr_x;
  } sample_t;

  typedef struct {
    logic [CB-1:0] org [3];
    logic [15:0]   head [3];
    logic          degen;
  } ray_t;

  typedef struct {
    sample_t smp;
    logic    fixed;   // expected ray typed in below
    ray_t    ray;
  } row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [63:0]   s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [111:0]  m_axis_tdata;
  logic          m_axis_tuser;
  logic          cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [3*CB-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  thin_lens_ray_generator i_dut (.*);

  longint cam_vec [NUM_REGS][3];
  ray_t   pending_rays [$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     allow_idle = 1'b1;
  bit     hold_off = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  function automatic longint sext(input logic [CB-1:0] v);
    return v[CB-1] ? longint'(v) - (longint'(1) << CB) : longint'(v);
  endfunction

  function automatic bit same_ray(input ray_t a, input ray_t b);
    bit eq;
    eq = (a.degen === b.degen);
    for (int k = 0; k < 3; k++)
      eq = eq && (a.org[k] === b.org[k]) && (a.head[k] === b.head[k]);
    return eq;
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic ray_t trace_ray(input sample_t s);
    ray_t r;
    longint one = longint'(1) << SB;
    longint du = 2 * longint'(s.lens_x) - one;
    longint dv = 2 * longint'(s.lens_y) - one;
    longint lens_pt, img_pt, diff, o;
    longint unsigned mag [3];
    longint unsigned maxm = 0, sum = 0, len, q;
    bit neg [3];
    int blen = 0;
    for (int k = 0; k < 3; k++) begin
      lens_pt = cam_vec[REG_LENS_CENTER][k] * one + du * cam_vec[REG_LENS_U][k]
              + dv * cam_vec[REG_LENS_V][k];
      img_pt  = cam_vec[REG_PLANE_CORNER][k] * one + longint'(s.scr_x) * cam_vec[REG_PLANE_X_SPAN][k]
              + longint'(s.scr_y) * cam_vec[REG_PLANE_Y_SPAN][k];
      diff = img_pt - lens_pt;
      o = (lens_pt + (one >> 1)) >>> SB;   // arithmetic shift floors
      if (o > (longint'(1) << (CB-1)) - 1) o = (longint'(1) << (CB-1)) - 1;
      if (o < -(longint'(1) << (CB-1))) o = -(longint'(1) << (CB-1));
      r.org[k] = o[CB-1:0];
      neg[k] = diff < 0;
      mag[k] = neg[k] ? longint'(-diff) : diff;
      if (mag[k] > maxm) maxm = mag[k];
    end
    r.degen = (maxm == 0);
    for (int k = 0; k < 3; k++) r.head[k] = '0;
    if (r.degen) return r;
    while (blen < 64 && (maxm >> blen) != 0) blen++;
    for (int k = 0; k < 3; k++) begin
      if (blen > NORM_BITS) mag[k] >>= (blen - NORM_BITS);
      else mag[k] <<= (NORM_BITS - blen);
      sum += mag[k] * mag[k];
    end
    len = isqrt(sum);
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << 15) + (len >> 1)) / len;
      if (neg[k]) r.head[k] = (q > 32768) ? 16'h8000 : 16'(-longint'(q));
      else r.head[k] = (q > 32767) ? HEAD_MAX : 16'(q);
    end
    return r;
  endfunction

  function automatic logic [3*CB-1:0] pack_vec(input int x, input int y, input int z);
    return {CB'(z), CB'(y), CB'(x)};
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [3*CB-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    for (int k = 0; k < 3; k++)
      cam_vec[idx][k] = sext(val[k*CB +: CB]);
    @(posedge clk_i);
  endtask

  task automatic send_sample(input sample_t s);
    while (allow_idle && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    pending_rays.push_back(trace_ray(s));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_rays.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic sample_t random_sample;
    sample_t s;
    s = {$urandom, $urandom};
    return s;
  endfunction

  // receiver with random stalls and an optional long hold-off
  always @(posedge clk_i) begin
    ray_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_rays.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          want = pending_rays.pop_front();
          for (int k = 0; k < 3; k++) begin
            if (m_axis_tdata[k*CB +: CB] !== want.org[k])
              report($sformatf("origin[%0d]", k), sext(m_axis_tdata[k*CB +: CB]),
                     sext(want.org[k]));
            if (m_axis_tdata[3*CB + 16*k +: 16] !== want.head[k])
              report($sformatf("heading[%0d]", k),
                     longint'($signed(m_axis_tdata[3*CB + 16*k +: 16])),
                     longint'($signed(want.head[k])));
          end
          if (m_axis_tuser !== want.degen) report("degenerate", m_axis_tuser, want.degen);
        end
      end
      m_axis_tready <= !hold_off && !(allow_idle && $urandom_range(99) < 30);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  row_t dir_rows [$];

  task automatic add_row(input sample_t s, input logic fx, input ray_t r);
    row_t w;
    w.smp = s; w.fixed = fx; w.ray = r;
    dir_rows.push_back(w);
  endtask

  initial begin
    ray_t zero_ray, got;
    sample_t s;
    for (int i = 0; i < NUM_REGS; i++)
      for (int k = 0; k < 3; k++) cam_vec[i][k] = 0;
    zero_ray.degen = 1'b1;
    for (int k = 0; k < 3; k++) begin
      zero_ray.org[k] = '0;
      zero_ray.head[k] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset every vector is zero: zero origin, degenerate ray
    add_row(64'h0, 1'b1, zero_ray);
    add_row(64'hffff_ffff_ffff_ffff, 1'b1, zero_ray);
    foreach (dir_rows[i]) begin
      got = trace_ray(dir_rows[i].smp);
      if (dir_rows[i].fixed && !same_ray(got, dir_rows[i].ray)) report("table row", i, 0);
      send_sample(dir_rows[i].smp);
    end
    drain();

    // plain camera: eye at origin, plane at z = -1
    write_reg(REG_LENS_CENTER, pack_vec(0, 0, 0));
    write_reg(REG_LENS_U, pack_vec(16, 0, 0));
    write_reg(REG_LENS_V, pack_vec(0, 16, 0));
    write_reg(REG_PLANE_CORNER, pack_vec(-1024, -1024, -1024));
    write_reg(REG_PLANE_X_SPAN, pack_vec(2048, 0, 0));
    write_reg(REG_PLANE_Y_SPAN, pack_vec(0, 2048, 0));
    send_sample('{16'h8000, 16'h8000, 16'h8000, 16'h8000}); // straight ahead
    send_sample('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_sample('{16'hffff, 16'hffff, 16'hffff, 16'hffff});
    send_sample('{16'h0000, 16'hffff, 16'hffff, 16'h0000});
    drain();

    // axis-aligned headings hit plus and minus one; extremes saturate the origin
    write_reg(REG_PLANE_CORNER, pack_vec(4096, 0, 0));
    write_reg(REG_PLANE_X_SPAN, pack_vec(0, 0, 0));
    write_reg(REG_PLANE_Y_SPAN, pack_vec(0, 0, 0));
    write_reg(REG_LENS_U, pack_vec(0, 0, 0));
    write_reg(REG_LENS_V, pack_vec(0, 0, 0));
    send_sample('{16'h8000, 16'h8000, 16'h1234, 16'h4321});
    drain();
    write_reg(REG_PLANE_CORNER, pack_vec(-4096, 0, 0));
    send_sample('{16'h8000, 16'h8000, 16'h1234, 16'h4321});
    drain();
    write_reg(REG_LENS_CENTER, pack_vec(1048575, -1048576, 1048575));
    write_reg(REG_LENS_U, pack_vec(1048575, -1048576, 1048575));
    write_reg(REG_LENS_V, pack_vec(-1048576, 1048575, 1048575));
    write_reg(REG_PLANE_CORNER, pack_vec(-1048576, 1048575, -1048576));
    write_reg(REG_PLANE_X_SPAN, pack_vec(-1048576, -1048576, 1048575));
    write_reg(REG_PLANE_Y_SPAN, pack_vec(1048575, 1048575, -1048576));
    send_sample('{16'hffff, 16'hffff, 16'hffff, 16'hffff});
    send_sample('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_sample('{16'h0000, 16'hffff, 16'h0000, 16'hffff});
    send_sample('{16'hffff, 16'h0000, 16'hffff, 16'h0000});
    drain();

    // random cameras and samples, with small vectors now and then
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        logic [3*CB-1:0] v;
        v = (3*CB)'({$urandom, $urandom});
        if (ph[0]) for (int k = 0; k < 3; k++)
          v[k*CB +: CB] = CB'($signed(12'($urandom)));
        write_reg(cfg_reg_e'(r), v);
      end
      allow_idle = (ph != 2);
      for (int i = 0; i < RANDOM_RAYS / 6; i++) begin
        s = random_sample();
        if ($urandom_range(9) == 0) s.lens_x = 16'h8000;
        send_sample(s);
        if (ph == 4 && i == 20) begin
          hold_off = 1'b1;
          fork
            begin
              repeat (200) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
      end
      drain();
    end

    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/tlrg_pkg.sv
hw/rtl/tlrg_front.sv
hw/rtl/tlrg_norm.sv
hw/rtl/tlrg_sqrt.sv
hw/rtl/tlrg_div.sv
hw/rtl/thin_lens_ray_generator.sv
bench/thin_lens_ray_generator_test.sv
